// ===== rtl/ring_frame_allocator_evict_oldest_defines.svh =====
// ----------------------------------------------------------------------------
// Frame allocator assertion macros
// Concurrent check macros shared by the allocator RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RING_FRAME_ALLOCATOR_EVICT_OLDEST_DEFINES_SVH
`define RING_FRAME_ALLOCATOR_EVICT_OLDEST_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds -> cons holds in the same cycle
`define RFA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// ante holds -> cons holds in the next cycle
`define RFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

// expr holds at every edge out of reset
`define RFA_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
		else $error("%m: invariant check failed");

`else

`define RFA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define RFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`define RFA_ASSERT_ALWAYS(lbl, clk, rstn, expr)

`endif

`endif

// ===== rtl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame allocator package
// Constants, field widths, result codes and shared types.
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int ALIGN_BYTES  = 16;
	localparam int HEADER_BYTES = 40;
	localparam int MAX_FRAMES   = 32;
	localparam int ADDR_BITS    = 20;

	localparam int ALIGN_LOG2 = $clog2(ALIGN_BYTES);

	localparam int OFF_W  = 20;
	localparam int SIZE_W = 21;
	localparam int SEQ_W  = 64;
	// wide enough for aligned tail end plus a full frame size
	localparam int CALC_W = 23;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 21;

	localparam logic [CFG_IDX_W-1:0] REG_ARENA_SIZE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WORKSPACE_START = 1'b1;

	localparam logic [SIZE_W-1:0] ARENA_RESET = 21'd65536;
	localparam logic [OFF_W-1:0]  WS_RESET    = 20'd256;
	localparam logic [SIZE_W-1:0] ARENA_CAP   = SIZE_W'(1) << ADDR_BITS;

	typedef enum logic [1:0] {
		KIND_EVICT    = 2'd0,
		KIND_ALLOC    = 2'd1,
		KIND_OVERFLOW = 2'd2
	} kind_t;

	typedef struct packed {
		logic [OFF_W-1:0]  off;
		logic [SIZE_W-1:0] size;
	} desc_t;

	typedef struct packed {
		logic             valid;
		kind_t            kind;
		logic [OFF_W-1:0] off;
		logic [SEQ_W-1:0] seq;
		logic             last;
	} emit_t;

	function automatic logic [CALC_W-1:0] align_down(input logic [CALC_W-1:0] x);
		return (x >> ALIGN_LOG2) << ALIGN_LOG2;
	endfunction

endpackage

// ===== rtl/rfa_if.sv =====
// ----------------------------------------------------------------------------
// Frame allocator channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rfa_req_if;
	logic                       valid;
	logic                       ready;
	logic [rfa_pkg::SIZE_W-1:0] payload_size;

	modport source (output valid, output payload_size, input ready);
	modport sink   (input valid, input payload_size, output ready);
endinterface

interface rfa_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                kind;
	logic [rfa_pkg::OFF_W-1:0] frame_offset;
	logic [rfa_pkg::SEQ_W-1:0] frame_seq;
	logic                      last;

	modport source (output valid, output kind, output frame_offset, output frame_seq,
		output last, input ready);
	modport sink   (input valid, input kind, input frame_offset, input frame_seq,
		input last, output ready);
endinterface

interface rfa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rfa_pkg::CFG_IDX_W-1:0]  index;
	logic [rfa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ring_frame_allocator_evict_oldest.sv =====
// ----------------------------------------------------------------------------
// Ring frame allocator, evict oldest
// Places header-plus-payload frames in a byte arena used as a ring and
// reports evicted, allocated or overflowed frames.
// ----------------------------------------------------------------------------
// Each request takes one word and yields one or more result words, the last
// flagged. With an empty store a request runs S_FIT2 and S_APPEND; otherwise
// S_TAIL reads the tail, S_FIT or, after a wrap, S_FIT2 checks the fit, and
// S_OV1 and S_OV2 check the head frame before S_APPEND. An overflow ends in
// S_FIT2, and result stalls hold the request. All address arithmetic runs
// through one shared adder/comparator under a small sequencer, and the head
// and tail descriptors come from a RAM with a registered read port, so each
// evicted frame adds a pass through S_HEAD, S_OV1 and S_OV2, except the one
// that empties the store, which adds none. The result register lets the
// next request be taken while a final result waits. The descriptor RAM needs
// no clearing after reset. Configuration writes are always ready and must
// only be issued while no request is in progress.
`include "ring_frame_allocator_evict_oldest_defines.svh"

module ring_frame_allocator_evict_oldest #(
	parameter int MAX_FRAMES = rfa_pkg::MAX_FRAMES
) (
	input  logic         clk,
	input  logic         arst_n,
	rfa_req_if.sink      req,
	rfa_rsp_if.source    rsp,
	rfa_cfg_if.sink      cfg
);

	localparam int CNT_W = $clog2(MAX_FRAMES + 1);

	logic [rfa_pkg::SIZE_W-1:0] arena_q;
	logic [rfa_pkg::OFF_W-1:0]  ws_q;
	logic                       out_valid_q;
	logic [1:0]                 out_kind_q;
	logic [rfa_pkg::OFF_W-1:0]  out_off_q;
	logic [rfa_pkg::SEQ_W-1:0]  out_seq_q;
	logic                       out_last_q;

	rfa_pkg::emit_t             emit;
	logic                       seq_idle;
	logic [CNT_W-1:0]           seq_count;
	logic                       out_free;
	logic                       start;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= rfa_pkg::ARENA_RESET;
			ws_q    <= rfa_pkg::WS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				rfa_pkg::REG_ARENA_SIZE:      arena_q <= cfg.data;
				rfa_pkg::REG_WORKSPACE_START: ws_q    <= cfg.data[rfa_pkg::OFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign req.ready = seq_idle;
	assign start     = req.valid && seq_idle;
	assign out_free  = !out_valid_q || rsp.ready;

	rfa_seq #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.psize      (req.payload_size),
		.arena_size (arena_q),
		.ws         (ws_q),
		.out_free   (out_free),
		.emit       (emit),
		.idle       (seq_idle),
		.count      (seq_count)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			out_kind_q <= emit.kind;
			out_off_q  <= emit.off;
			out_seq_q  <= emit.seq;
			out_last_q <= emit.last;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.kind         = out_kind_q;
	assign rsp.frame_offset = out_off_q;
	assign rsp.frame_seq    = out_seq_q;
	assign rsp.last         = out_last_q;

	`RFA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready)
	`RFA_ASSERT_ALWAYS(a_count_bound, clk, arst_n, seq_count <= CNT_W'(MAX_FRAMES))
	`RFA_ASSERT_IMPLY(a_alloc_nonempty, clk, arst_n, rsp.valid && rsp.ready && rsp.kind == rfa_pkg::KIND_ALLOC, seq_count != '0)
	`RFA_ASSERT_IMPLY(a_evict_not_last, clk, arst_n, rsp.valid && rsp.kind == rfa_pkg::KIND_EVICT, !rsp.last)

endmodule

// ===== rtl/rfa_addcmp.sv =====
// ----------------------------------------------------------------------------
// Frame allocator shared add/compare unit
// One adder with a magnitude compare of the sum against a third operand.
// ----------------------------------------------------------------------------
module rfa_addcmp (
	input  logic [rfa_pkg::CALC_W-1:0] a,
	input  logic [rfa_pkg::CALC_W-1:0] b,
	input  logic [rfa_pkg::CALC_W-1:0] c,
	output logic [rfa_pkg::CALC_W-1:0] y,
	output logic                       lt,
	output logic                       gt
);

	always_comb begin
		y  = a + b;
		lt = (y < c);
		gt = (y > c);
	end

endmodule

// ===== rtl/rfa_desc_ram.sv =====
// ----------------------------------------------------------------------------
// Frame allocator descriptor RAM
// One write port, one registered read port; contents undefined until written.
// ----------------------------------------------------------------------------
module rfa_desc_ram #(
	parameter int DEPTH = rfa_pkg::MAX_FRAMES
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  rfa_pkg::desc_t           wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output rfa_pkg::desc_t           rdata_q
);

	rfa_pkg::desc_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

// ===== rtl/rfa_seq.sv =====
// ----------------------------------------------------------------------------
// Frame allocator sequencer
// Walks one request through placement, fit checks and eviction using the
// shared add/compare unit and the descriptor RAM.
// ----------------------------------------------------------------------------
module rfa_seq #(
	parameter int MAX_FRAMES = rfa_pkg::MAX_FRAMES
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [rfa_pkg::SIZE_W-1:0]           psize,
	input  logic [rfa_pkg::SIZE_W-1:0]           arena_size,
	input  logic [rfa_pkg::OFF_W-1:0]            ws,
	input  logic                                 out_free,
	output rfa_pkg::emit_t                       emit,
	output logic                                 idle,
	output logic [$clog2(MAX_FRAMES+1)-1:0]      count
);

	localparam int PTR_W = $clog2(MAX_FRAMES);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W = CNT_W + 1;
	localparam int CW    = rfa_pkg::CALC_W;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_TAIL   = 8'b0000_0010,
		S_FIT    = 8'b0000_0100,
		S_FIT2   = 8'b0000_1000,
		S_OV1    = 8'b0001_0000,
		S_OV2    = 8'b0010_0000,
		S_HEAD   = 8'b0100_0000,
		S_APPEND = 8'b1000_0000
	} state_t;

	state_t                      state_q;
	logic [rfa_pkg::SIZE_W-1:0]  psize_q;
	logic [CW-1:0]               fsz_q;
	logic [CW-1:0]               off_q;
	logic                        ov1_q;
	logic [PTR_W-1:0]            rptr_q;
	logic [CNT_W-1:0]            count_q;
	logic [rfa_pkg::OFF_W-1:0]   head_q;
	logic [rfa_pkg::OFF_W-1:0]   tail_q;
	logic [rfa_pkg::SEQ_W-1:0]   oldest_q;
	logic [rfa_pkg::SEQ_W-1:0]   newest_q;

	logic [SUM_W-1:0]            tsum;
	logic [SUM_W-1:0]            wsum;
	logic [PTR_W-1:0]            tidx;
	logic [PTR_W-1:0]            widx;
	logic [PTR_W-1:0]            rptr_inc;
	logic [rfa_pkg::SIZE_W-1:0]  lim;
	logic [CW-1:0]               ua, ub, uc, uy;
	logic                        ult, ugt;
	logic                        full;
	logic                        evict;
	logic [rfa_pkg::SEQ_W-1:0]   next_seq;
	rfa_pkg::desc_t              rd_desc;
	rfa_pkg::desc_t              wr_desc;
	logic                        we;
	logic [PTR_W-1:0]            raddr;

	// ring positions of the newest entry and of the next free entry
	always_comb begin
		tsum = SUM_W'(rptr_q) + SUM_W'(count_q) - SUM_W'(1);
		if (tsum >= SUM_W'(MAX_FRAMES)) begin
			tsum = tsum - SUM_W'(MAX_FRAMES);
		end
		wsum = SUM_W'(rptr_q) + SUM_W'(count_q);
		if (wsum >= SUM_W'(MAX_FRAMES)) begin
			wsum = wsum - SUM_W'(MAX_FRAMES);
		end
		tidx = tsum[PTR_W-1:0];
		widx = wsum[PTR_W-1:0];
		if (SUM_W'(rptr_q) == SUM_W'(MAX_FRAMES - 1)) begin
			rptr_inc = '0;
		end else begin
			rptr_inc = rptr_q + PTR_W'(1);
		end
	end

	assign lim      = (arena_size > rfa_pkg::ARENA_CAP) ? rfa_pkg::ARENA_CAP : arena_size;
	assign full     = (count_q == CNT_W'(MAX_FRAMES));
	assign next_seq = newest_q + rfa_pkg::SEQ_W'(1);

	// operand selection for the shared unit
	always_comb begin
		ua = '0;
		ub = '0;
		uc = '0;
		unique case (state_q) inside
			S_TAIL: begin
				ua = CW'(tail_q);
				ub = CW'(rfa_pkg::HEADER_BYTES + rfa_pkg::ALIGN_BYTES - 1) + CW'(rd_desc.size);
			end
			S_FIT, S_FIT2: begin
				ua = off_q;
				ub = fsz_q;
				uc = CW'(lim);
			end
			S_OV1: begin
				ua = CW'(rd_desc.off);
				ub = CW'(rfa_pkg::HEADER_BYTES) + CW'(rd_desc.size);
				uc = off_q;
			end
			S_OV2: begin
				ua = off_q;
				ub = fsz_q;
				uc = CW'(head_q);
			end
			default: begin
			end
		endcase
	end

	rfa_addcmp u_addcmp (
		.a  (ua),
		.b  (ub),
		.c  (uc),
		.y  (uy),
		.lt (ult),
		.gt (ugt)
	);

	// head frame overlaps the new slot, or the store has no free entry
	assign evict = (ov1_q && ugt) || full;

	assign raddr   = (state_q == S_IDLE) ? tidx : rptr_q;
	assign we      = (state_q == S_APPEND) && out_free;
	assign wr_desc = '{off: off_q[rfa_pkg::OFF_W-1:0], size: psize_q};

	rfa_desc_ram #(
		.DEPTH (MAX_FRAMES)
	) u_desc_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (widx),
		.wdata   (wr_desc),
		.raddr   (raddr),
		.rdata_q (rd_desc)
	);

	always_comb begin
		emit = '0;
		emit.kind = rfa_pkg::KIND_EVICT;
		unique case (state_q)
			S_FIT2: begin
				if (!ult && out_free) begin
					emit.valid = 1'b1;
					emit.kind  = rfa_pkg::KIND_OVERFLOW;
					emit.last  = 1'b1;
				end
			end
			S_OV2: begin
				if (evict && out_free) begin
					emit.valid = 1'b1;
					emit.kind  = rfa_pkg::KIND_EVICT;
					emit.off   = head_q;
					emit.seq   = oldest_q;
				end
			end
			S_APPEND: begin
				if (out_free) begin
					emit.valid = 1'b1;
					emit.kind  = rfa_pkg::KIND_ALLOC;
					emit.off   = off_q[rfa_pkg::OFF_W-1:0];
					emit.seq   = next_seq;
					emit.last  = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ov1_q    <= 1'b0;
			rptr_q   <= '0;
			count_q  <= '0;
			head_q   <= '0;
			tail_q   <= '0;
			oldest_q <= '0;
			newest_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= (count_q == '0) ? S_FIT2 : S_TAIL;
					end
				end
				S_TAIL: begin
					state_q <= S_FIT;
				end
				S_FIT: begin
					state_q <= ult ? S_OV1 : S_FIT2;
				end
				S_FIT2: begin
					if (ult) begin
						state_q <= (count_q == '0) ? S_APPEND : S_OV1;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_OV1: begin
					ov1_q   <= ugt;
					head_q  <= rd_desc.off;
					state_q <= S_OV2;
				end
				S_OV2: begin
					if (!evict) begin
						state_q <= S_APPEND;
					end else if (out_free) begin
						rptr_q   <= rptr_inc;
						count_q  <= count_q - CNT_W'(1);
						oldest_q <= oldest_q + rfa_pkg::SEQ_W'(1);
						if (count_q == CNT_W'(1)) begin
							head_q  <= '0;
							tail_q  <= '0;
							state_q <= S_APPEND;
						end else begin
							state_q <= S_HEAD;
						end
					end
				end
				S_HEAD: begin
					// RAM read of the new head lands next cycle
					state_q <= S_OV1;
				end
				S_APPEND: begin
					if (out_free) begin
						newest_q <= next_seq;
						if (count_q == '0) begin
							oldest_q <= next_seq;
							head_q   <= off_q[rfa_pkg::OFF_W-1:0];
						end
						count_q <= count_q + CNT_W'(1);
						tail_q  <= off_q[rfa_pkg::OFF_W-1:0];
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request word and placement candidate
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			psize_q <= psize;
			fsz_q   <= CW'(rfa_pkg::HEADER_BYTES) + CW'(psize);
			off_q   <= CW'(ws);
		end else if (state_q == S_TAIL) begin
			off_q <= rfa_pkg::align_down(uy);
		end else if (state_q == S_FIT && !ult) begin
			off_q <= CW'(ws);
		end
	end

	assign idle  = (state_q == S_IDLE);
	assign count = count_q;

endmodule
